@@ design/nls_pkg.sv @@
package nls_pkg;

    localparam int PC_W = 4;

    // Fixed-point constants; mantissa in Q16.32, series in Q30
    localparam logic [33:0] ONE_Q32     = 34'h1_0000_0000;
    localparam logic [47:0] HIGH_BOUND  = 48'h0001_8000_0000;
    localparam logic [47:0] LOW_BOUND   = 48'h0000_8000_0000;
    localparam logic [34:0] LN2_Q30     = 35'd744261118;
    localparam logic [34:0] ROUND_HALF  = 35'd32;
    localparam logic [4:0]  DIV_STEPS   = 5'd30;

    typedef enum logic [3:0] {
        OP_NORM    = 4'd0,
        OP_DIVSET  = 4'd1,
        OP_DIVSTEP = 4'd2,
        OP_SQUARE  = 4'd3,
        OP_T2      = 4'd4,
        OP_MULT    = 4'd5,
        OP_RECIP   = 4'd6,
        OP_BACK    = 4'd7,
        OP_ACCUM   = 4'd8,
        OP_EXPO    = 4'd9,
        OP_FINISH  = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT      = 3'd0,
        J_STAY_NORM = 3'd1,
        J_STAY_DIV  = 3'd2,
        J_LOOP_TERM = 3'd3,
        J_DONE      = 3'd4
    } jump_t;

    typedef struct packed {
        op_t              op;
        jump_t            jump;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] PC_NORM    = 4'd0;
    localparam logic [PC_W-1:0] PC_DIVSET  = 4'd1;
    localparam logic [PC_W-1:0] PC_DIVSTEP = 4'd2;
    localparam logic [PC_W-1:0] PC_SQUARE  = 4'd3;
    localparam logic [PC_W-1:0] PC_T2      = 4'd4;
    localparam logic [PC_W-1:0] PC_MULT    = 4'd5;
    localparam logic [PC_W-1:0] PC_RECIP   = 4'd6;
    localparam logic [PC_W-1:0] PC_BACK    = 4'd7;
    localparam logic [PC_W-1:0] PC_ACCUM   = 4'd8;
    localparam logic [PC_W-1:0] PC_EXPO    = 4'd9;
    localparam logic [PC_W-1:0] PC_FINISH  = 4'd10;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_NORM:    w = '{op: OP_NORM,    jump: J_STAY_NORM, target: PC_NORM};
            PC_DIVSET:  w = '{op: OP_DIVSET,  jump: J_NEXT,      target: PC_NORM};
            PC_DIVSTEP: w = '{op: OP_DIVSTEP, jump: J_STAY_DIV,  target: PC_NORM};
            PC_SQUARE:  w = '{op: OP_SQUARE,  jump: J_NEXT,      target: PC_NORM};
            PC_T2:      w = '{op: OP_T2,      jump: J_NEXT,      target: PC_NORM};
            PC_MULT:    w = '{op: OP_MULT,    jump: J_NEXT,      target: PC_NORM};
            PC_RECIP:   w = '{op: OP_RECIP,   jump: J_NEXT,      target: PC_NORM};
            PC_BACK:    w = '{op: OP_BACK,    jump: J_NEXT,      target: PC_NORM};
            PC_ACCUM:   w = '{op: OP_ACCUM,   jump: J_LOOP_TERM, target: PC_MULT};
            PC_EXPO:    w = '{op: OP_EXPO,    jump: J_NEXT,      target: PC_NORM};
            PC_FINISH:  w = '{op: OP_FINISH,  jump: J_DONE,      target: PC_NORM};
            default:    w = '{op: OP_FINISH,  jump: J_DONE,      target: PC_NORM};
        endcase
        return w;
    endfunction

endpackage

@@ design/natural_log_series.sv @@
// Channel  | Handshake          | Payload                         | Direction
// ---------+--------------------+---------------------------------+----------
// in       | in_valid/in_stall  | x_value (Q16.16, unsigned)      | into block
// out      | out_valid/out_stall| log_value (Q8.24), domain_error | out of block
//
// One operand at a time: the mantissa takes 0 to 16 normalising shifts, then the 30-step
// restoring divider forms t and the four-step term loop on the shared multiplier sums
// the series. A zero operand skips these steps and goes straight to the final step.
// rst_n clears the sequencer and the output valid at once.
// A result held by out_stall freezes the last step; the next operand waits on in_stall.
module natural_log_series #(
    parameter int SERIES_TERMS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        x_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] log_value,
    output logic               domain_error
);

    localparam int IDX_W = $clog2(SERIES_TERMS);

    // Control
    logic                      busy_reg, busy_next;
    logic [nls_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic                      out_valid_reg, out_valid_next;
    nls_pkg::ctrl_word_t       cw;
    logic                      in_take, out_free, step_en, finish_en;

    // Datapath
    logic [47:0]        m_reg, m_next;
    logic [5:0]         expo_reg, expo_next;
    logic               zero_reg, zero_next;
    logic               neg_reg, neg_next;
    logic [33:0]        den_reg, den_next;
    logic [33:0]        rem_reg, rem_next;
    logic [29:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [28:0]        term_reg, term_next;
    logic [27:0]        t2_reg, t2_next;
    logic [29:0]        sum_reg, sum_next;
    logic [59:0]        prod_reg, prod_next;
    logic [27:0]        q_reg, q_next;
    logic [28:0]        chk_reg, chk_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [34:0]        lnk_reg, lnk_next;
    logic signed [31:0] log_reg;
    logic               dom_reg;

    // Helpers
    logic               above, below;
    logic [33:0]        m34, diff, den_w;
    logic [33:0]        rem_init;
    logic [34:0]        r2, rsub;
    logic               ge;
    logic [59:0]        tm60, term60, t260, sc60, rc60;
    logic [28:0]        q29, d29, chk_w, rmd;
    logic               bump;
    logic [IDX_W:0]     dval;
    logic [34:0]        expo_ext, sum2, sgn_sum, total, rnd;
    logic               last_term;
    logic [30:0]        recip_tab [SERIES_TERMS];

    // Reciprocal floor(2^32 / (2g+1)) for each odd divisor
    for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_recip
        localparam logic [32:0] RECIP = (33'd1 << 32) / (33'(2 * g + 1));
        assign recip_tab[g] = RECIP[30:0];
    end

    assign cw        = nls_pkg::ucode_rom(pc_reg);
    assign in_take   = in_valid && !busy_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_en   = busy_reg && ((cw.op != nls_pkg::OP_FINISH) || out_free);
    assign finish_en = step_en && (cw.op == nls_pkg::OP_FINISH);

    assign in_stall     = busy_reg;
    assign out_valid    = out_valid_reg;
    assign log_value    = log_reg;
    assign domain_error = dom_reg;

    assign above    = m_reg > nls_pkg::HIGH_BOUND;
    assign below    = m_reg < nls_pkg::LOW_BOUND;
    assign m34      = {1'b0, m_reg[32:0]};
    assign diff     = (m34 < nls_pkg::ONE_Q32) ? (nls_pkg::ONE_Q32 - m34)
                                               : (m34 - nls_pkg::ONE_Q32);
    assign den_w    = m34 + nls_pkg::ONE_Q32;
    // Upper part of |m-1|*2^30 + den/2, the lower 30 bits are den[30:1]
    assign rem_init = {2'd0, diff[31:0]} + {31'd0, den_w[33:31]};

    assign r2   = {rem_reg, quo_reg[29]};
    assign rsub = r2 - {1'b0, den_reg};
    assign ge   = r2 >= {1'b0, den_reg};

    assign tm60   = {31'd0, quo_reg[28:0]};
    assign term60 = {31'd0, term_reg};
    assign t260   = {32'd0, t2_reg};
    assign sc60   = {31'd0, prod_reg[58:30]};
    assign rc60   = {29'd0, recip_tab[idx_reg]};

    assign dval  = {idx_reg, 1'b1};
    assign d29   = 29'(dval);
    assign q29   = {1'b0, prod_reg[59:32]};
    assign chk_w = q29 * d29;
    assign rmd   = term_reg - chk_reg;
    // The reciprocal estimate is at most one short
    assign bump  = rmd >= d29;

    assign last_term = idx_reg == IDX_W'(SERIES_TERMS - 1);

    assign expo_ext = {{29{expo_reg[5]}}, expo_reg};
    assign sum2     = {4'd0, sum_reg, 1'b0};
    assign sgn_sum  = neg_reg ? (35'd0 - sum2) : sum2;
    assign total    = sgn_sum + lnk_reg;
    assign rnd      = total + nls_pkg::ROUND_HALF;

    // Sequencer
    always_comb
    begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (in_take)
        begin
            busy_next = 1'b1;
            pc_next   = (x_value == 32'd0) ? nls_pkg::PC_FINISH : nls_pkg::PC_NORM;
        end
        else if (step_en)
        begin
            case (cw.jump)
                nls_pkg::J_NEXT:
                begin
                    pc_next = pc_reg + nls_pkg::PC_W'(1);
                end
                nls_pkg::J_STAY_NORM:
                begin
                    if (!above && !below)
                    begin
                        pc_next = pc_reg + nls_pkg::PC_W'(1);
                    end
                end
                nls_pkg::J_STAY_DIV:
                begin
                    if (cnt_reg == 5'd1)
                    begin
                        pc_next = pc_reg + nls_pkg::PC_W'(1);
                    end
                end
                nls_pkg::J_LOOP_TERM:
                begin
                    pc_next = last_term ? (pc_reg + nls_pkg::PC_W'(1)) : cw.target;
                end
                nls_pkg::J_DONE:
                begin
                    busy_next      = 1'b0;
                    out_valid_next = 1'b1;
                    pc_next        = nls_pkg::PC_NORM;
                end
                default:
                begin
                    pc_next = nls_pkg::PC_NORM;
                end
            endcase
        end
    end

    // Datapath
    always_comb
    begin
        m_next    = m_reg;
        expo_next = expo_reg;
        zero_next = zero_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        term_next = term_reg;
        t2_next   = t2_reg;
        sum_next  = sum_reg;
        prod_next = prod_reg;
        q_next    = q_reg;
        chk_next  = chk_reg;
        idx_next  = idx_reg;
        lnk_next  = lnk_reg;
        if (in_take)
        begin
            m_next    = {x_value, 16'd0};
            expo_next = 6'd0;
            zero_next = x_value == 32'd0;
        end
        else if (step_en)
        begin
            case (cw.op)
                nls_pkg::OP_NORM:
                begin
                    if (above)
                    begin
                        m_next    = {1'b0, m_reg[47:1]};
                        expo_next = expo_reg + 6'd1;
                    end
                    else if (below)
                    begin
                        m_next    = {m_reg[46:0], 1'b0};
                        expo_next = expo_reg - 6'd1;
                    end
                end
                nls_pkg::OP_DIVSET:
                begin
                    neg_next = m34 < nls_pkg::ONE_Q32;
                    den_next = den_w;
                    rem_next = rem_init;
                    quo_next = den_w[30:1];
                    cnt_next = nls_pkg::DIV_STEPS;
                end
                nls_pkg::OP_DIVSTEP:
                begin
                    rem_next = ge ? rsub[33:0] : r2[33:0];
                    quo_next = {quo_reg[28:0], ge};
                    cnt_next = cnt_reg - 5'd1;
                end
                nls_pkg::OP_SQUARE:
                begin
                    prod_next = tm60 * tm60;
                    term_next = quo_reg[28:0];
                    sum_next  = {1'b0, quo_reg[28:0]};
                    idx_next  = IDX_W'(1);
                end
                nls_pkg::OP_T2:
                begin
                    t2_next = prod_reg[57:30];
                end
                nls_pkg::OP_MULT:
                begin
                    prod_next = term60 * t260;
                end
                nls_pkg::OP_RECIP:
                begin
                    term_next = prod_reg[58:30];
                    prod_next = sc60 * rc60;
                end
                nls_pkg::OP_BACK:
                begin
                    q_next   = prod_reg[59:32];
                    chk_next = chk_w;
                end
                nls_pkg::OP_ACCUM:
                begin
                    sum_next = sum_reg + {2'd0, q_reg} + {29'd0, bump};
                    idx_next = idx_reg + IDX_W'(1);
                end
                nls_pkg::OP_EXPO:
                begin
                    lnk_next = expo_ext * nls_pkg::LN2_Q30;
                end
                nls_pkg::OP_FINISH:
                begin
                    lnk_next = lnk_reg;
                end
                default:
                begin
                    lnk_next = lnk_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= nls_pkg::PC_NORM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        expo_reg <= expo_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        term_reg <= term_next;
        t2_reg   <= t2_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        chk_reg  <= chk_next;
        idx_reg  <= idx_next;
        lnk_reg  <= lnk_next;
        // Load the result register only when the previous transaction has gone
        if (finish_en)
        begin
            dom_reg <= zero_reg;
            log_reg <= zero_reg ? 32'sd0 : {{3{rnd[34]}}, rnd[34:6]};
        end
    end

    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pc_reg == nls_pkg::PC_DIVSET)
            |-> (m_reg >= nls_pkg::LOW_BOUND && m_reg <= nls_pkg::HIGH_BOUND))
        else $error("mantissa left normalisation out of range");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pc_reg == nls_pkg::PC_DIVSTEP) |-> cnt_reg != 5'd0)
        else $error("divider step count ran out");

    a_term_index: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pc_reg == nls_pkg::PC_ACCUM)
            |-> (idx_reg != '0 && idx_reg <= IDX_W'(SERIES_TERMS - 1)))
        else $error("series term index out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && pc_reg == nls_pkg::PC_FINISH))
        else $error("result raised outside the final step");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dom_reg) |-> log_reg == 32'sd0)
        else $error("domain error with nonzero logarithm");

endmodule

@@ verif/nls_checker.sv @@
module nls_checker #(
    parameter int TERMS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [31:0]        x_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] log_value,
    input  logic               domain_error,
    output int                 errors,
    output int                 pending
);

    localparam logic [63:0] MANT_ONE  = 64'h0000_0001_0000_0000;
    localparam logic [63:0] MANT_HIGH = 64'h0000_0001_8000_0000;
    localparam logic [63:0] MANT_LOW  = 64'h0000_0000_8000_0000;
    localparam longint      LN2_Q30   = 64'd744261118;
    localparam logic [63:0] BIAS_Q30  = 64'd1 << 40;

    typedef struct packed {
        logic [31:0] log_q24;
        logic        dom_err;
    } ln_result_t;

    ln_result_t expected_logs[$];

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic ln_result_t predict_ln_q24(input logic [31:0] x);
        ln_result_t  r;
        logic [63:0] mant;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] t_mag;
        logic [63:0] t_sq;
        logic [63:0] power;
        logic [63:0] series;
        logic [63:0] biased;
        longint      expo;
        longint      total;
        logic        below_one;
        r = '0;
        if (x == 32'd0)
        begin
            r.dom_err = 1'b1;
            return r;
        end
        mant = {16'd0, x, 16'd0};
        expo = 0;
        // a mantissa of exactly 1.5 is left alone
        while (mant > MANT_HIGH)
        begin
            mant = mant >> 1;
            expo = expo + 1;
        end
        while (mant < MANT_LOW)
        begin
            mant = mant << 1;
            expo = expo - 1;
        end
        below_one = mant < MANT_ONE;
        mag = below_one ? (MANT_ONE - mant) : (mant - MANT_ONE);
        den = mant + MANT_ONE;
        t_mag = ((mag << 30) + (den >> 1)) / den;
        t_sq = mul_q30(t_mag, t_mag);
        power = t_mag;
        series = t_mag;
        for (int i = 1; i < TERMS; i++)
        begin
            power = mul_q30(power, t_sq);
            series = series + power / 64'(2 * i + 1);
        end
        total = longint'(series << 1);
        if (below_one)
            total = -total;
        total = total + expo * LN2_Q30;
        // round half up to Q24 via a positive bias
        biased = 64'(total) + BIAS_Q30;
        biased = (biased + 64'd32) >> 6;
        biased = biased - (BIAS_Q30 >> 6);
        r.log_q24 = biased[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ln_result_t want;
        if (!rst_n)
        begin
            expected_logs.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            // retire the result first: it always belongs to an older transaction
            if (out_valid && !out_stall)
            begin
                if (expected_logs.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none, got log_value=%h domain_error=%b",
                             $time, log_value, domain_error);
                end
                else
                begin
                    want = expected_logs.pop_front();
                    if (log_value !== want.log_q24)
                    begin
                        errors = errors + 1;
                        $display("%0t: log_value mismatch, expected %h, got %h",
                                 $time, want.log_q24, log_value);
                    end
                    if (domain_error !== want.dom_err)
                    begin
                        errors = errors + 1;
                        $display("%0t: domain_error mismatch, expected %b, got %b",
                                 $time, want.dom_err, domain_error);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_logs.push_back(predict_ln_q24(x_value));
            pending <= expected_logs.size();
        end
    end

endmodule

@@ verif/tb_natural_log_series.sv @@
module tb_natural_log_series;

    localparam int TERMS          = 16;
    localparam int ITEMS_PER_LEG  = 270;
    localparam int QUIET_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 150;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [31:0]        x_value   = 32'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] log_value;
    logic               domain_error;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always #1 clk = ~clk;

    natural_log_series #(
        .SERIES_TERMS(TERMS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_value      (x_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .log_value    (log_value),
        .domain_error (domain_error)
    );

    nls_checker #(
        .TERMS(TERMS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_value      (x_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .log_value    (log_value),
        .domain_error (domain_error),
        .errors       (errors),
        .pending      (pending)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // end the run if no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_natural_log_series: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_operand(input logic [31:0] x);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            x_value  <= $urandom;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        // hold the payload until the transaction is taken
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        int          sel;
        int          shift;
        logic [31:0] base;
        sel   = $urandom_range(0, 99);
        shift = $urandom_range(0, 15);
        if (sel < 4)
            return 32'd0;
        else if (sel < 35)
            return $urandom;
        else if (sel < 70)
            // spread the exponent across the whole range
            return $urandom >> $urandom_range(0, 31);
        else
        begin
            // land near the mantissa bounds and unity
            case ($urandom_range(0, 2))
                0:       base = 32'h0001_8000;
                1:       base = 32'h0000_8000;
                default: base = 32'h0001_0000;
            endcase
            base = base + 32'($urandom_range(0, 6)) - 32'd3;
            if ($urandom_range(0, 1) == 0)
                return base << shift;
            else
                return base >> shift;
        end
    endfunction

    initial
    begin
        logic [31:0] directed [24];
        directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                     32'h0001_8000, 32'h0000_8000, 32'h0001_7FFF, 32'h0001_8001,
                     32'h0000_7FFF, 32'h0000_8001, 32'h8000_0000, 32'h0000_0002,
                     32'h0003_0000, 32'h0000_C000, 32'h0002_8000, 32'h0002_B7E1,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0003, 32'h0000_FFFF,
                     32'h0001_0001, 32'h7FFF_FFFF, 32'h0000_0000, 32'hC000_0000};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_operand(directed[i]);
        wait_drained();

        for (int leg = 0; leg < 4; leg++)
        begin
            case (leg)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_LEG; n++)
                send_operand(pick_operand());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_natural_log_series: done, clean");
        else
            $display("tb_natural_log_series: done, errors");
        $finish;
    end

endmodule

@@ natural_log_series.f @@
design/nls_pkg.sv
design/natural_log_series.sv
verif/nls_checker.sv
verif/tb_natural_log_series.sv
